// File: sv/generational_handle_table_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the generational handle table
// Clocked on clk, disabled while arst_n is low; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_CORE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define GHT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define GHT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GHT_ASSERT_IMP(lbl, ante, cons, msg)
`define GHT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Word types, operation and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

	localparam logic [2:0] OP_ALLOC     = 3'd0;
	localparam logic [2:0] OP_RELEASE   = 3'd1;
	localparam logic [2:0] OP_TEST      = 3'd2;
	localparam logic [2:0] OP_ATTACH    = 3'd3;
	localparam logic [2:0] OP_DETACH    = 3'd4;
	localparam logic [2:0] OP_READ_LIST = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_STALE   = 2'd2;
	localparam logic [1:0] ST_NO_FLAG = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [9:0]  handle_index;
		logic [31:0] handle_generation;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  result_index;
		logic [31:0] result_generation;
		logic        flag_value;
		logic [9:0]  live_count;
	} rsp_t;

	typedef struct packed {
		logic capture; // latch the request word
		logic look;    // first memory read
		logic chain;   // dependent slot read for a live-list lookup
		logic exec;    // evaluate, write back, load result
	} dp_cmd_t;

	typedef struct packed {
		logic need_chain;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: sv/ght_ctrl.sv
// ----------------------------------------------------------------------------
// ght_ctrl
// Sequencer for one request at a time; owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "generational_handle_table_core_assert.svh"

module ght_ctrl import ght_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_LOOK  = 2'd1;
	localparam logic [1:0] S_CHAIN = 2'd2;
	localparam logic [1:0] S_EXEC  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       rsp_valid_q;
	logic       rsp_free;

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	assign cmd.capture = req_valid && req_ready;
	assign cmd.look    = (state_q == S_LOOK);
	assign cmd.chain   = (state_q == S_CHAIN);
	assign cmd.exec    = (state_q == S_EXEC) && rsp_free;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_nx = S_LOOK;
			end
			S_LOOK: begin
				state_nx = stat.need_chain ? S_CHAIN : S_EXEC;
			end
			S_CHAIN: begin
				state_nx = S_EXEC;
			end
			S_EXEC: begin
				if (rsp_free) state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`GHT_ASSERT_NXT(a_exec_waits, state_q == S_EXEC && rsp_valid_q && !rsp_ready, state_q == S_EXEC, "exec left while result word still held")
	`GHT_ASSERT_NXT(a_accept_look, req_valid && req_ready, state_q == S_LOOK, "accepted word did not start a lookup")
	`GHT_ASSERT_IMP(a_cmd_excl, 1'b1, $onehot0({cmd.capture, cmd.look, cmd.chain, cmd.exec}), "datapath commands overlap")

endmodule

`default_nettype wire

// File: sv/ght_dp.sv
// ----------------------------------------------------------------------------
// ght_dp
// Slot, back-pointer, live-list and free-stack memories with counters.
// ----------------------------------------------------------------------------
`default_nettype none

`include "generational_handle_table_core_assert.svh"

module ght_dp import ght_pkg::*; #(
	parameter int SLOTS    = 1024,
	parameter int GEN_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output rsp_t     rsp
);

	localparam int SW = $clog2(SLOTS);
	localparam int GW = GEN_BITS;
	localparam int EW = SW + GW;

	// slot entry: {flag, generation}
	logic [GW:0]   slot_mem [SLOTS];
	logic [SW-1:0] pos_mem  [SLOTS];
	logic [SW-1:0] list_mem [SLOTS];
	logic [EW-1:0] stk_mem  [SLOTS];

	req_t          req_q;
	logic [SW-1:0] top_q;   // free stack depth
	logic [SW-1:0] live_q;  // live list length
	logic [SW-1:0] low_q;   // lowest stack depth ever popped to
	rsp_t          rsp_q;

	logic [GW:0]   slot_rd_q;
	logic [SW-1:0] pos_rd_q;
	logic [SW-1:0] list_rd_q;
	logic [EW-1:0] stk_rd_q;

	logic [2:0]    op;
	logic [SW-1:0] idx_slot;
	logic          idx_in_range;
	logic          idx_in_live;
	logic [SW-1:0] slot_ra;
	logic [SW-1:0] list_ra;
	logic [SW-1:0] exec_slot;
	logic          slot_fresh;
	logic [GW-1:0] gen_cur;
	logic          flag_cur;
	logic          handle_ok;
	logic [SW-1:0] pop_pos;
	logic          pop_init;
	logic [SW-1:0] pop_slot;
	logic [GW-1:0] pop_gen;
	logic [GW-1:0] gen_inc;
	logic [GW-1:0] gen_next;
	logic          full;

	logic          slot_we;
	logic [SW-1:0] slot_wa;
	logic [GW:0]   slot_wd;
	logic          pos_we;
	logic [SW-1:0] pos_wa;
	logic [SW-1:0] pos_wd;
	logic          list_we;
	logic [SW-1:0] list_wa;
	logic [SW-1:0] list_wd;
	logic          stk_we;
	logic [SW-1:0] top_nx;
	logic [SW-1:0] live_nx;
	logic [SW-1:0] low_nx;
	rsp_t          rsp_nx;

	assign op           = req_q.operation;
	assign idx_slot     = SW'(req_q.handle_index);
	assign idx_in_range = 32'(req_q.handle_index) < 32'(SLOTS);
	assign idx_in_live  = 32'(req_q.handle_index) < 32'(live_q);
	assign stat.need_chain = (op == OP_READ_LIST);

	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= req;
	end

	// ---- reads -------------------------------------------------------------
	assign slot_ra = cmd.chain ? list_rd_q : idx_slot;
	assign list_ra = (op == OP_READ_LIST) ? idx_slot : live_q - SW'(1);

	always_ff @(posedge clk) begin
		if (cmd.look || cmd.chain) slot_rd_q <= slot_mem[slot_ra];
		if (cmd.look) begin
			pos_rd_q  <= pos_mem[idx_slot];
			list_rd_q <= list_mem[list_ra];
			stk_rd_q  <= stk_mem[top_q - SW'(1)];
		end
	end

	// ---- evaluate ----------------------------------------------------------
	// A slot at or below the low mark was never handed out, so its entry is read
	// as free with flag clear, whatever the memory holds. Slot 0 always lands here.
	assign exec_slot  = (op == OP_READ_LIST) ? list_rd_q : idx_slot;
	assign slot_fresh = (exec_slot <= low_q);
	assign gen_cur    = slot_fresh ? '0 : slot_rd_q[GW-1:0];
	assign flag_cur   = slot_fresh ? 1'b0 : slot_rd_q[GW];
	assign handle_ok  = idx_in_range && (gen_cur != '0)
		&& (32'(gen_cur) == req_q.handle_generation);

	// stack entries below the low mark still hold their seed: slot depth+1
	assign pop_pos  = top_q - SW'(1);
	assign pop_init = (pop_pos < low_q);
	assign pop_slot = pop_init ? top_q : stk_rd_q[EW-1:GW];
	assign pop_gen  = pop_init ? GW'(1) : stk_rd_q[GW-1:0];
	assign full     = (top_q == '0);

	assign gen_inc  = gen_cur + GW'(1);
	assign gen_next = (gen_inc == '0) ? GW'(1) : gen_inc;

	always_comb begin
		slot_we = 1'b0;
		slot_wa = idx_slot;
		slot_wd = {flag_cur, gen_cur};
		pos_we  = 1'b0;
		pos_wa  = pop_slot;
		pos_wd  = live_q;
		list_we = 1'b0;
		list_wa = live_q;
		list_wd = pop_slot;
		stk_we  = 1'b0;
		top_nx  = top_q;
		live_nx = live_q;
		low_nx  = low_q;
		rsp_nx.status            = ST_OK;
		rsp_nx.result_index      = '0;
		rsp_nx.result_generation = '0;
		rsp_nx.flag_value        = 1'b0;

		unique case (op)
			OP_ALLOC: begin
				if (full) begin
					rsp_nx.status = ST_FULL;
				end else begin
					slot_we = 1'b1;
					slot_wa = pop_slot;
					slot_wd = {1'b0, pop_gen};
					pos_we  = 1'b1;
					list_we = 1'b1;
					top_nx  = top_q - SW'(1);
					live_nx = live_q + SW'(1);
					if (pop_init) low_nx = pop_pos;
					rsp_nx.result_index      = 10'(pop_slot);
					rsp_nx.result_generation = 32'(pop_gen);
				end
			end
			OP_RELEASE: begin
				if (!handle_ok) begin
					rsp_nx.status = ST_STALE;
				end else begin
					// swap-remove: last live slot moves into the freed position
					slot_we = 1'b1;
					slot_wd = '0;
					list_we = 1'b1;
					list_wa = pos_rd_q;
					list_wd = list_rd_q;
					pos_we  = 1'b1;
					pos_wa  = list_rd_q;
					pos_wd  = pos_rd_q;
					stk_we  = 1'b1;
					top_nx  = top_q + SW'(1);
					live_nx = live_q - SW'(1);
				end
			end
			OP_TEST: begin
				if (!handle_ok) rsp_nx.status = ST_STALE;
				else rsp_nx.flag_value = flag_cur;
			end
			OP_ATTACH: begin
				if (!handle_ok) begin
					rsp_nx.status = ST_STALE;
				end else begin
					slot_we = 1'b1;
					slot_wd = {1'b1, gen_cur};
					rsp_nx.flag_value = 1'b1;
				end
			end
			OP_DETACH: begin
				if (!handle_ok) begin
					rsp_nx.status = ST_STALE;
				end else if (flag_cur) begin
					slot_we = 1'b1;
					slot_wd = {1'b0, gen_cur};
				end else begin
					rsp_nx.status = ST_NO_FLAG;
				end
			end
			OP_READ_LIST: begin
				if (!idx_in_live) begin
					rsp_nx.status = ST_STALE;
				end else begin
					rsp_nx.result_index      = 10'(list_rd_q);
					rsp_nx.result_generation = 32'(gen_cur);
					rsp_nx.flag_value        = flag_cur;
				end
			end
			default: begin
				rsp_nx.status = ST_STALE;
			end
		endcase
		rsp_nx.live_count = 10'(live_nx);
	end

	// ---- writes ------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (cmd.exec && slot_we) slot_mem[slot_wa] <= slot_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && pos_we) pos_mem[pos_wa] <= pos_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && list_we) list_mem[list_wa] <= list_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && stk_we) stk_mem[top_q] <= {idx_slot, gen_next};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= SW'(SLOTS - 1);
			live_q <= '0;
			low_q  <= SW'(SLOTS - 1);
		end else if (cmd.exec) begin
			top_q  <= top_nx;
			live_q <= live_nx;
			low_q  <= low_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) rsp_q <= rsp_nx;
	end

	assign rsp = rsp_q;

	`GHT_ASSERT_IMP(a_slot_balance, 1'b1, 32'(live_q) + 32'(top_q) == 32'(SLOTS - 1), "live plus free count lost a slot")
	`GHT_ASSERT_IMP(a_low_mark, 1'b1, low_q <= top_q, "low mark above stack depth")

endmodule

`default_nettype wire

// File: sv/generational_handle_table_core.sv
// ----------------------------------------------------------------------------
// generational_handle_table_core
// Generational handle allocator: free stack, per-slot generation and flag,
// dense live list with back pointers.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready, req): one word per operation --
//   allocate, release, test handle, attach flag, detach flag, read live list.
//   Response channel (rsp_valid/rsp_ready, rsp): exactly one word per request,
//   in request order, carrying status, handle or list entry, flag and count.
//   Sequence: the request word is captured on acceptance, the lookup reads the
//   memories, a live-list read adds a dependent slot read, and the registered
//   response word is loaded in the final step, which waits while a word is held.
//   Overlap: a new request is taken only after the last one's response word is
//   loaded; each slot memory has one read and one write port, and the
//   read-evaluate-write pass is not overlapped between requests.
//   Reset: counters clear at once; no memory sweep is run. The free stack's
//   seed and the slots' free state come from a low-water mark on stack depth,
//   so the block takes requests as soon as reset is released.
//   Stall: a held response word does not block acceptance of the next
//   request; that request waits in its final step until the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table_core import ght_pkg::*; #(
	parameter int SLOTS    = 1024,
	parameter int GEN_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// command/status between the sequencer and the datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: request capture, lookup, optional chained read, write-back
	ght_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// memories, counters and the registered response word
	ght_dp #(
		.SLOTS    (SLOTS),
		.GEN_BITS (GEN_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
